// File: rtl/swfr_pkg.sv
// ----------------------------------------------------------------------------
// swfr_pkg
// Shared constants and types of the stop-and-wait frame receiver.
// ----------------------------------------------------------------------------
package swfr_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] ESC_BYTE  = 8'h7d;
  localparam logic [7:0] ESC_MASK  = 8'h20;
  localparam logic [7:0] SEQ0_CTRL = 8'h00;
  localparam logic [7:0] SEQ1_CTRL = 8'h40;

  localparam int unsigned NUM_CFG = 8;

  localparam logic [2:0] R_ADDR = 3'd0;
  localparam logic [2:0] R_SET  = 3'd1;
  localparam logic [2:0] R_UA   = 3'd2;
  localparam logic [2:0] R_DISC = 3'd3;
  localparam logic [2:0] R_RR0  = 3'd4;
  localparam logic [2:0] R_RR1  = 3'd5;
  localparam logic [2:0] R_REJ0 = 3'd6;
  localparam logic [2:0] R_REJ1 = 3'd7;

  localparam logic [7:0] CFG_RESET [NUM_CFG] = '{
    8'd3, 8'd3, 8'd7, 8'd11, 8'd5, 8'd133, 8'd1, 8'd129
  };

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_REPLY   = 2'd1;
  localparam logic [1:0] KIND_EVENT   = 2'd2;

  localparam logic [2:0] EV_DATA_OK = 3'd0;
  localparam logic [2:0] EV_DUP     = 3'd1;
  localparam logic [2:0] EV_BCC2    = 3'd2;
  localparam logic [2:0] EV_OPENED  = 3'd3;
  localparam logic [2:0] EV_DISC    = 3'd4;
  localparam logic [2:0] EV_CLOSED  = 3'd5;
  localparam logic [2:0] EV_ABORT   = 3'd6;

  // Result burst held between input and output side.
  typedef enum logic [1:0] {
    B_PAYLOAD = 2'd0,
    B_REPLY   = 2'd1,
    B_EVENT   = 2'd2
  } burst_mode_t;

  typedef struct packed {
    burst_mode_t mode;
    logic [7:0]  data;
    logic [2:0]  ev;
  } burst_t;

  localparam logic [2:0] REPLY_LAST_IDX = 3'd5;

endpackage

// File: rtl/stop_wait_frame_receiver.sv
// ----------------------------------------------------------------------------
// stop_wait_frame_receiver
// Receiving side of a stop-and-wait HDLC-style link: header hunt, byte
// destuffing, BCC2 check, link phase tracking and reply generation.
// ----------------------------------------------------------------------------
// One line byte is accepted per cycle while in_stall is low. Each byte
// updates the frame and link state in the cycle it is accepted and loads a
// burst register with the results it causes; the output side drains that
// burst one beat per cycle while out_stall is low. A payload byte or a
// single event is one beat, so bytes keep that rate; a frame end that sends
// a reply is six beats (five reply bytes and the event). The next byte is
// taken in the cycle the final beat of a burst leaves.
module stop_wait_frame_receiver
  import swfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [2:0] event_code,
  output logic       last
);

  localparam logic [2:0] ST_HUNT = 3'd0;
  localparam logic [2:0] ST_FLAG = 3'd1;
  localparam logic [2:0] ST_ADDR = 3'd2;
  localparam logic [2:0] ST_CTRL = 3'd3;
  localparam logic [2:0] ST_SUPV = 3'd4;
  localparam logic [2:0] ST_DATA = 3'd5;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_OPEN    = 2'd1;
  localparam logic [1:0] PH_CLOSING = 2'd2;

  logic [7:0] cfg [NUM_CFG];

  logic [2:0] frame_state, frame_state_next;
  logic       escape_pending, escape_pending_next;
  logic [1:0] link_phase, link_phase_next;
  logic [7:0] control_seen, control_seen_next;
  logic       expected_seq, expected_seq_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_valid, held_valid_next;
  logic [7:0] running_xor, running_xor_next;

  logic       burst_valid;
  burst_t     burst;
  logic [2:0] idx;
  logic       burst_load;
  burst_t     burst_next;

  logic       in_accept;
  logic       out_take;
  logic       is_flag;
  logic       is_iframe_b;
  logic       is_iframe_seen;
  logic       ctrl_ok;
  logic       seq_seen;
  logic [7:0] destuffed;

  assign out_valid = burst_valid;
  assign out_take  = burst_valid && !out_stall;
  assign in_stall  = burst_valid && !(out_take && last);
  assign in_accept = in_valid && !in_stall;

  assign is_flag        = (rx_byte == FLAG_BYTE);
  assign is_iframe_b    = (rx_byte == SEQ0_CTRL) || (rx_byte == SEQ1_CTRL);
  assign is_iframe_seen = (control_seen == SEQ0_CTRL) || (control_seen == SEQ1_CTRL);
  assign seq_seen       = (control_seen == SEQ1_CTRL);
  assign destuffed      = escape_pending ? (rx_byte ^ ESC_MASK) : rx_byte;

  always_comb begin
    case (link_phase)
      PH_IDLE:    ctrl_ok = (rx_byte == cfg[R_SET]);
      PH_OPEN:    ctrl_ok = is_iframe_b || (rx_byte == cfg[R_DISC]);
      PH_CLOSING: ctrl_ok = (rx_byte == cfg[R_UA]);
      default:    ctrl_ok = 1'b0;
    endcase
  end

  always_comb begin
    frame_state_next    = frame_state;
    escape_pending_next = escape_pending;
    link_phase_next     = link_phase;
    control_seen_next   = control_seen;
    expected_seq_next   = expected_seq;
    held_byte_next      = held_byte;
    held_valid_next     = held_valid;
    running_xor_next    = running_xor;
    burst_load          = 1'b0;
    burst_next.mode     = B_EVENT;
    burst_next.data     = 8'h00;
    burst_next.ev       = EV_DATA_OK;

    case (frame_state)
      ST_HUNT: begin
        if (is_flag) frame_state_next = ST_FLAG;
      end
      ST_FLAG: begin
        if (rx_byte == cfg[R_ADDR]) frame_state_next = ST_ADDR;
        else if (!is_flag) frame_state_next = ST_HUNT;
      end
      ST_ADDR: begin
        if (ctrl_ok) begin
          control_seen_next = rx_byte;
          frame_state_next  = ST_CTRL;
        end else begin
          frame_state_next = is_flag ? ST_FLAG : ST_HUNT;
        end
      end
      ST_CTRL: begin
        if (rx_byte == (cfg[R_ADDR] ^ control_seen)) begin
          if (link_phase == PH_OPEN && is_iframe_seen) begin
            frame_state_next    = ST_DATA;
            escape_pending_next = 1'b0;
            held_valid_next     = 1'b0;
            running_xor_next    = 8'h00;
          end else begin
            frame_state_next = ST_SUPV;
          end
        end else begin
          frame_state_next = is_flag ? ST_FLAG : ST_HUNT;
        end
      end
      ST_SUPV: begin
        if (is_flag) begin
          frame_state_next = ST_FLAG;
          burst_load       = 1'b1;
          case (link_phase)
            PH_IDLE: begin
              link_phase_next   = PH_OPEN;
              expected_seq_next = 1'b0;
              burst_next.mode   = B_REPLY;
              burst_next.data   = cfg[R_UA];
              burst_next.ev     = EV_OPENED;
            end
            PH_OPEN: begin
              link_phase_next = PH_CLOSING;
              burst_next.mode = B_REPLY;
              burst_next.data = cfg[R_DISC];
              burst_next.ev   = EV_DISC;
            end
            default: begin
              link_phase_next = PH_IDLE;
              burst_next.ev   = EV_CLOSED;
            end
          endcase
        end else begin
          frame_state_next = ST_HUNT;
        end
      end
      ST_DATA: begin
        if (is_flag) begin
          frame_state_next    = ST_FLAG;
          escape_pending_next = 1'b0;
          held_valid_next     = 1'b0;
          burst_load          = 1'b1;
          if (escape_pending) begin
            burst_next.ev = EV_ABORT;
          end else if (held_valid && running_xor == held_byte) begin
            burst_next.mode = B_REPLY;
            if (seq_seen == expected_seq) begin
              expected_seq_next = !expected_seq;
              burst_next.data   = expected_seq ? cfg[R_RR0] : cfg[R_RR1];
              burst_next.ev     = EV_DATA_OK;
            end else begin
              burst_next.data = expected_seq ? cfg[R_RR1] : cfg[R_RR0];
              burst_next.ev   = EV_DUP;
            end
          end else begin
            burst_next.mode = B_REPLY;
            burst_next.data = expected_seq ? cfg[R_REJ1] : cfg[R_REJ0];
            burst_next.ev   = EV_BCC2;
          end
        end else if (!escape_pending && rx_byte == ESC_BYTE) begin
          escape_pending_next = 1'b1;
        end else begin
          escape_pending_next = 1'b0;
          if (held_valid) begin
            running_xor_next = running_xor ^ held_byte;
            if (seq_seen == expected_seq) begin
              burst_load      = 1'b1;
              burst_next.mode = B_PAYLOAD;
              burst_next.data = held_byte;
            end
          end
          held_byte_next  = destuffed;
          held_valid_next = 1'b1;
        end
      end
      default: begin
        frame_state_next = ST_HUNT;
      end
    endcase
  end

  always_comb begin
    out_kind   = KIND_EVENT;
    out_byte   = 8'h00;
    event_code = burst.ev;
    last       = 1'b1;
    case (burst.mode)
      B_PAYLOAD: begin
        out_kind   = KIND_PAYLOAD;
        out_byte   = burst.data;
        event_code = EV_DATA_OK;
      end
      B_REPLY: begin
        last = (idx == REPLY_LAST_IDX);
        if (idx != REPLY_LAST_IDX) begin
          out_kind   = KIND_REPLY;
          event_code = EV_DATA_OK;
        end
        case (idx)
          3'd0:    out_byte = FLAG_BYTE;
          3'd1:    out_byte = cfg[R_ADDR];
          3'd2:    out_byte = burst.data;
          3'd3:    out_byte = cfg[R_ADDR] ^ burst.data;
          3'd4:    out_byte = FLAG_BYTE;
          default: out_byte = 8'h00;
        endcase
      end
      default: begin
        out_kind = KIND_EVENT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CFG; i++) cfg[i] <= CFG_RESET[i];
    end else if (cfg_we) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_state    <= ST_HUNT;
      escape_pending <= 1'b0;
      link_phase     <= PH_IDLE;
      control_seen   <= 8'h00;
      expected_seq   <= 1'b0;
      held_valid     <= 1'b0;
      running_xor    <= 8'h00;
    end else if (in_accept) begin
      frame_state    <= frame_state_next;
      escape_pending <= escape_pending_next;
      link_phase     <= link_phase_next;
      control_seen   <= control_seen_next;
      expected_seq   <= expected_seq_next;
      held_valid     <= held_valid_next;
      running_xor    <= running_xor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) held_byte <= held_byte_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
      idx         <= 3'd0;
    end else if (in_accept && burst_load) begin
      burst_valid <= 1'b1;
      idx         <= 3'd0;
    end else if (out_take) begin
      if (last) begin
        burst_valid <= 1'b0;
        idx         <= 3'd0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && burst_load) burst <= burst_next;
  end

`ifndef ASSERT_OFF
  a_held_in_data: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> frame_state == ST_DATA)
    else $error("held byte outside payload");

  a_esc_in_data: assert property (@(posedge clk) disable iff (rst)
    escape_pending |-> frame_state == ST_DATA)
    else $error("escape pending outside payload");

  a_phase_code: assert property (@(posedge clk) disable iff (rst)
    link_phase != 2'd3)
    else $error("bad link phase");

  a_reply_event: assert property (@(posedge clk) disable iff (rst)
    (burst_valid && burst.mode == B_REPLY) |->
      (burst.ev != EV_CLOSED && burst.ev != EV_ABORT))
    else $error("reply burst with no-reply event");

  a_idx_wrap: assert property (@(posedge clk) disable iff (rst)
    (out_take && last) |=> idx == 3'd0)
    else $error("beat index not restarted");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    burst_valid |-> (idx <= REPLY_LAST_IDX))
    else $error("beat index past burst");
`endif

endmodule

// File: tb/tb_stop_wait_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_stop_wait_frame_receiver
// Feeds line bytes (framed traffic, broken frames, noise) into the receiver
// under random idling on both channels, across several register settings.
// A scoreboard tracks frame and link state per accepted byte and checks each
// output beat in order against the payload, reply and event beats it predicts.
// ----------------------------------------------------------------------------
module tb_stop_wait_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;
  import swfr_pkg::*;

  typedef enum logic [2:0] {ST_HUNT, ST_FLAG, ST_ADDR, ST_CTRL, ST_SUPV, ST_DATA} rx_state_t;
  typedef enum logic [1:0] {PH_IDLE, PH_OPEN, PH_CLOSING} link_phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] ev;
    logic       fin;
  } beat_t;

  localparam int FR_GOOD      = 0;
  localparam int FR_BAD_CHECK = 1;
  localparam int FR_ABORT     = 2;
  localparam int FR_EMPTY     = 3;

  class frame_link_scoreboard;
    logic [7:0]  regs [NUM_CFG];
    rx_state_t   state;
    logic        esc_pend;
    link_phase_t phase;
    logic [7:0]  ctrl_seen;
    logic        exp_seq;
    logic [7:0]  held;
    logic        held_v;
    logic [7:0]  xor_acc;
    beat_t       pending_beats [$];
    int          errors;

    function new();
      for (int i = 0; i < NUM_CFG; i++) regs[i] = CFG_RESET[i];
      state     = ST_HUNT;
      esc_pend  = 1'b0;
      phase     = PH_IDLE;
      ctrl_seen = 8'h00;
      exp_seq   = 1'b0;
      held      = 8'h00;
      held_v    = 1'b0;
      xor_acc   = 8'h00;
      errors    = 0;
    endfunction

    function void add_beat(logic [1:0] kind, logic [7:0] data, logic [2:0] ev);
      beat_t b;
      b.kind = kind;
      b.data = data;
      b.ev   = ev;
      b.fin  = 1'b0;
      pending_beats.push_back(b);
    endfunction

    function void add_reply(logic [7:0] ctrl);
      add_beat(KIND_REPLY, FLAG_BYTE, EV_DATA_OK);
      add_beat(KIND_REPLY, regs[R_ADDR], EV_DATA_OK);
      add_beat(KIND_REPLY, ctrl, EV_DATA_OK);
      add_beat(KIND_REPLY, regs[R_ADDR] ^ ctrl, EV_DATA_OK);
      add_beat(KIND_REPLY, FLAG_BYTE, EV_DATA_OK);
    endfunction

    function bit is_iframe(logic [7:0] c);
      return c == SEQ0_CTRL || c == SEQ1_CTRL;
    endfunction

    function bit ctrl_ok(logic [7:0] c);
      case (phase)
        PH_IDLE:    return c == regs[R_SET];
        PH_OPEN:    return is_iframe(c) || c == regs[R_DISC];
        PH_CLOSING: return c == regs[R_UA];
        default:    return 1'b0;
      endcase
    endfunction

    function void close_data();
      logic seq;
      seq = (ctrl_seen == SEQ1_CTRL);
      if (esc_pend) begin
        add_beat(KIND_EVENT, 8'h00, EV_ABORT);
      end else if (held_v && xor_acc == held) begin
        if (seq == exp_seq) begin
          exp_seq = ~exp_seq;
          add_reply(exp_seq ? regs[R_RR1] : regs[R_RR0]);
          add_beat(KIND_EVENT, 8'h00, EV_DATA_OK);
        end else begin
          add_reply(exp_seq ? regs[R_RR1] : regs[R_RR0]);
          add_beat(KIND_EVENT, 8'h00, EV_DUP);
        end
      end else begin
        add_reply(exp_seq ? regs[R_REJ1] : regs[R_REJ0]);
        add_beat(KIND_EVENT, 8'h00, EV_BCC2);
      end
    endfunction

    function void close_supervisory();
      case (phase)
        PH_IDLE: begin
          phase   = PH_OPEN;
          exp_seq = 1'b0;
          add_reply(regs[R_UA]);
          add_beat(KIND_EVENT, 8'h00, EV_OPENED);
        end
        PH_OPEN: begin
          phase = PH_CLOSING;
          add_reply(regs[R_DISC]);
          add_beat(KIND_EVENT, 8'h00, EV_DISC);
        end
        default: begin
          phase = PH_IDLE;
          add_beat(KIND_EVENT, 8'h00, EV_CLOSED);
        end
      endcase
    endfunction

    function void take_line_byte(logic [7:0] b);
      int         n0;
      logic       flag;
      logic [7:0] d;
      n0   = pending_beats.size();
      flag = (b == FLAG_BYTE);
      case (state)
        ST_HUNT: begin
          if (flag) state = ST_FLAG;
        end
        ST_FLAG: begin
          if (b == regs[R_ADDR]) state = ST_ADDR;
          else if (!flag) state = ST_HUNT;
        end
        ST_ADDR: begin
          if (ctrl_ok(b)) begin
            ctrl_seen = b;
            state     = ST_CTRL;
          end else begin
            state = flag ? ST_FLAG : ST_HUNT;
          end
        end
        ST_CTRL: begin
          if (b == (regs[R_ADDR] ^ ctrl_seen)) begin
            if (phase == PH_OPEN && is_iframe(ctrl_seen)) begin
              state    = ST_DATA;
              esc_pend = 1'b0;
              held_v   = 1'b0;
              xor_acc  = 8'h00;
            end else begin
              state = ST_SUPV;
            end
          end else begin
            state = flag ? ST_FLAG : ST_HUNT;
          end
        end
        ST_SUPV: begin
          if (flag) begin
            close_supervisory();
            state = ST_FLAG;
          end else begin
            state = ST_HUNT;
          end
        end
        ST_DATA: begin
          if (flag) begin
            close_data();
            esc_pend = 1'b0;
            held_v   = 1'b0;
            state    = ST_FLAG;
          end else if (!esc_pend && b == ESC_BYTE) begin
            esc_pend = 1'b1;
          end else begin
            d        = esc_pend ? (b ^ ESC_MASK) : b;
            esc_pend = 1'b0;
            if (held_v) begin
              xor_acc = xor_acc ^ held;
              if ((ctrl_seen == SEQ1_CTRL) == exp_seq) add_beat(KIND_PAYLOAD, held, EV_DATA_OK);
            end
            held   = d;
            held_v = 1'b1;
          end
        end
        default: state = ST_HUNT;
      endcase
      if (pending_beats.size() > n0) pending_beats[pending_beats.size() - 1].fin = 1'b1;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_beat(logic [1:0] kind, logic [7:0] data, logic [2:0] ev, logic fin);
      beat_t e;
      if (pending_beats.size() == 0) begin
        report($sformatf("unexpected beat kind %0d byte %02h event %0d last %0b",
                         kind, data, ev, fin));
        return;
      end
      e = pending_beats.pop_front();
      if (kind !== e.kind || data !== e.data || ev !== e.ev || fin !== e.fin)
        report($sformatf(
          "beat got kind %0d byte %02h event %0d last %0b, want %0d %02h %0d %0b",
          kind, data, ev, fin, e.kind, e.data, e.ev, e.fin));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = 3'd0;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [2:0] event_code;
  logic       last;

  frame_link_scoreboard sb;
  bit          quiet = 1'b0;
  int          bytes_sent = 0;
  logic [7:0]  line_q [$];
  logic [7:0]  body_q [$];
  logic [7:0]  next_cfg [NUM_CFG];

  stop_wait_frame_receiver uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .event_code (event_code),
    .last       (last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_beat(out_kind, out_byte, event_code, last);
  end

  initial begin
    bit hold;
    int n;
    forever begin
      @(negedge clk);
      hold = !quiet && !rst && $urandom_range(0, 2) == 0;
      n    = $urandom_range(1, 9);
      out_stall <= hold;
      repeat (n - 1) @(negedge clk);
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return FLAG_BYTE;
      1:       return ESC_BYTE;
      2:       return FLAG_BYTE ^ ESC_MASK;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic bit use_lead();
    return (sb.state != ST_FLAG) || ($urandom_range(0, 3) != 0);
  endfunction

  task automatic send_byte(logic [7:0] b);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    sb.take_line_byte(b);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  // escape flag and escape bytes, and now and then any byte that allows it
  task automatic put_stuffed(logic [7:0] d);
    if (d == FLAG_BYTE || d == ESC_BYTE ||
        ((d ^ ESC_MASK) != FLAG_BYTE && $urandom_range(0, 9) == 0)) begin
      line_q.push_back(ESC_BYTE);
      line_q.push_back(d ^ ESC_MASK);
    end else begin
      line_q.push_back(d);
    end
  endtask

  task automatic fill_body(int len);
    body_q.delete();
    repeat (len) body_q.push_back(pick_byte());
  endtask

  task automatic send_iframe(bit seq, int mode, bit lead);
    logic [7:0] ctrl;
    logic [7:0] acc;
    ctrl = seq ? SEQ1_CTRL : SEQ0_CTRL;
    acc  = 8'h00;
    if (lead) line_q.push_back(FLAG_BYTE);
    line_q.push_back(sb.regs[R_ADDR]);
    line_q.push_back(ctrl);
    line_q.push_back(sb.regs[R_ADDR] ^ ctrl);
    if (mode != FR_EMPTY) begin
      foreach (body_q[i]) begin
        put_stuffed(body_q[i]);
        acc = acc ^ body_q[i];
      end
      if (mode == FR_ABORT) line_q.push_back(ESC_BYTE);
      else if (mode == FR_BAD_CHECK) put_stuffed(acc ^ 8'($urandom_range(1, 255)));
      else put_stuffed(acc);
    end
    line_q.push_back(FLAG_BYTE);
    send_line();
  endtask

  task automatic send_sframe(logic [7:0] ctrl, bit lead, bit closed);
    if (lead) line_q.push_back(FLAG_BYTE);
    line_q.push_back(sb.regs[R_ADDR]);
    line_q.push_back(ctrl);
    line_q.push_back(sb.regs[R_ADDR] ^ ctrl);
    line_q.push_back(closed ? FLAG_BYTE : 8'($urandom_range(0, 255)));
    send_line();
  endtask

  task automatic send_noise(int n);
    repeat (n) line_q.push_back(pick_byte());
    send_line();
  endtask

  task automatic send_bad_header();
    line_q.push_back(FLAG_BYTE);
    line_q.push_back($urandom_range(0, 3) == 0 ? pick_byte() : sb.regs[R_ADDR]);
    line_q.push_back($urandom_range(0, 1) == 0 ? pick_byte() : sb.regs[R_SET]);
    line_q.push_back(pick_byte());
    if ($urandom_range(0, 1) == 0) line_q.push_back(FLAG_BYTE);
    send_line();
  endtask

  // hold the sender until every predicted beat has come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_config();
    drain();
    for (int i = 0; i < NUM_CFG; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= next_cfg[i];
      sb.regs[i] = next_cfg[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_traffic(int budget);
    int stop_at;
    int r;
    int mode;
    int len;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_noise($urandom_range(1, 6));
      end else if (r < 12) begin
        send_bad_header();
      end else begin
        case (sb.phase)
          PH_IDLE: send_sframe(sb.regs[R_SET], use_lead(), $urandom_range(0, 9) != 0);
          PH_OPEN: begin
            if (r < 20) begin
              send_sframe(sb.regs[R_DISC], use_lead(), $urandom_range(0, 9) != 0);
            end else begin
              len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
              fill_body(len);
              r = $urandom_range(0, 99);
              mode = (r < 75) ? FR_GOOD : (r < 87) ? FR_BAD_CHECK :
                     (r < 94) ? FR_ABORT : FR_EMPTY;
              send_iframe(($urandom_range(0, 4) == 0) ? ~sb.exp_seq : sb.exp_seq, mode, use_lead());
            end
          end
          default: send_sframe(sb.regs[R_UA], use_lead(), $urandom_range(0, 9) != 0);
        endcase
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("stop_wait_frame_receiver regression: fail");
    $finish;
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    line_q = '{8'h00, 8'hff};
    send_line();
    send_sframe(sb.regs[R_SET], 1'b1, 1'b1);
    body_q = '{FLAG_BYTE, ESC_BYTE, 8'h00, 8'hff};
    send_iframe(1'b0, FR_GOOD, 1'b0);
    send_iframe(1'b0, FR_GOOD, 1'b0);
    body_q = '{8'h55};
    send_iframe(1'b1, FR_BAD_CHECK, 1'b0);
    send_iframe(1'b1, FR_EMPTY, 1'b0);
    send_iframe(1'b1, FR_ABORT, 1'b0);
    send_sframe(sb.regs[R_DISC], 1'b0, 1'b1);
    send_sframe(sb.regs[R_UA], 1'b0, 1'b1);
    drain();

    random_traffic(50);

    next_cfg = '{8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 8'h00};
    write_config();
    random_traffic(50);

    next_cfg = '{8'hff, 8'h00, 8'hff, 8'h80, 8'hff, 8'h00, 8'h00, 8'hff};
    write_config();
    random_traffic(50);

    for (int i = 0; i < NUM_CFG; i++) next_cfg[i] = 8'($urandom_range(0, 255));
    write_config();
    quiet = 1'b1;
    random_traffic(50);

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
      $display("stop_wait_frame_receiver regression: pass");
    end else begin
      $display("stop_wait_frame_receiver regression: fail");
    end
    $finish;
  end

endmodule
